// ===== hdl/pom_pkg.sv =====
// Shared types and constants of the perturb-and-observe power point tracker.
package pom_pkg;

  localparam int unsigned CfgDataW = 12;

  // Power is (current * quarter voltage) / 1000, done as a reciprocal multiply.
  localparam int unsigned RecipShift = 32;
  localparam logic [22:0] Recip1000  = 23'd4294968;

  localparam logic [9:0]  StepSizeReset         = 10'd16;
  localparam logic [11:0] SettingMaxReset       = 12'd4000;
  localparam logic [11:0] SettingMinReset       = 12'd100;
  localparam logic [11:0] SettingNominalReset   = 12'd2048;
  localparam logic [9:0]  PerturbsPerCycleReset = 10'd100;

  typedef enum logic [2:0] {
    CfgStepSize         = 3'd0,
    CfgSettingMax       = 3'd1,
    CfgSettingMin       = 3'd2,
    CfgSettingNominal   = 3'd3,
    CfgPerturbsPerCycle = 3'd4
  } cfg_index_e;

  typedef struct packed {
    logic                valid;
    cfg_index_e          index;
    logic [CfgDataW-1:0] data;
  } cfg_wr_t;

  typedef struct packed {
    logic [2:0]  panel;
    logic [11:0] current_sample;
    logic [11:0] voltage_sample;
    logic        shutdown;
    logic        cycle_start;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  panel;
    logic        shutdown;
    logic        cycle_start;
    logic [12:0] power;
  } work_t;

  typedef struct packed {
    logic [2:0]  panel_out;
    logic [11:0] current_setting;
    logic        direction_up;
    logic [12:0] power_value;
    logic        perturbed;
    logic        cycle_done;
  } out_item_t;

endpackage

// ===== hdl/perturb_observe_mppt.sv =====
// Top level of the multi-panel perturb-and-observe power point tracker.
//
//   Channel   Handshake                  Payload
//   --------  -------------------------  ------------------------------------
//   samples   push / full                in_item_i  (pom_pkg::in_item_t)
//   results   empty / pop                out_item_o (pom_pkg::out_item_t)
//   config    cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// One item is accepted per clock cycle while full is low; each item passes
// through the two power stages and the work queue to the back end, whose result
// waits in the result queue before it reaches the result ports.
// The rate is set by the back end, which reads and writes one panel's state per
// cycle. Reset puts every panel at the nominal setting, direction up, count
// zero, and loads the reset values of the settings. A stalled result side fills
// the output queue, then the work queue, then the power pipeline before full rises.
//
// The front end multiplies current by the quarter voltage, then divides by
// 1000 through a registered reciprocal multiply. A four-item work queue
// decouples it from the back end, which compares power with the panel's stored
// baseline, flips direction when it did not rise (not while shut down), and moves
// the setting by one step, falling back to nominal outside min..max.
module perturb_observe_mppt #(
  parameter int unsigned PANEL_COUNT = 6
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  pom_pkg::in_item_t  in_item_i,
  output logic               empty,
  input  logic               pop,
  output pom_pkg::out_item_t out_item_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [11:0]        cfg_data_i
);

  import pom_pkg::*;

  localparam int unsigned WorkDepth = 4;
  localparam int unsigned ResDepth  = 2;

  work_t     work_in, work_out;
  out_item_t res;
  cfg_wr_t   cfg;
  logic      work_push, work_full, work_pop, work_empty;
  logic      res_push, res_full;

  // Settings are plain registers, so a write is always taken at once.
  assign cfg_ready_o = 1'b1;
  assign cfg.valid   = cfg_valid_i;
  assign cfg.index   = cfg_index_e'(cfg_index_i);
  assign cfg.data    = cfg_data_i;

  pom_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (full),
    .in_item_i   (in_item_i),
    .work_push_o (work_push),
    .work_o      (work_in),
    .work_full_i (work_full)
  );

  pom_fifo #(
    .Width ($bits(work_t)),
    .Depth (WorkDepth)
  ) u_work_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (work_push),
    .data_i  (work_in),
    .full_o  (work_full),
    .pop_i   (work_pop),
    .data_o  (work_out),
    .empty_o (work_empty)
  );

  pom_back #(
    .PanelCount (PANEL_COUNT)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .work_empty_i (work_empty),
    .work_i       (work_out),
    .work_pop_o   (work_pop),
    .res_full_i   (res_full),
    .res_push_o   (res_push),
    .res_o        (res)
  );

  // Results wait here, so the back end keeps working while pop is low until the queue is full.
  pom_fifo #(
    .Width ($bits(out_item_t)),
    .Depth (ResDepth)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (out_item_o),
    .empty_o (empty)
  );

endmodule

// ===== hdl/pom_fifo.sv =====
// Small first-in first-out queue built from registers.
module pom_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             wr_en, rd_en;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign wr_en   = push_i && !full_o;
  assign rd_en   = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (wr_en) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (rd_en) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (wr_en && !rd_en) begin
      cnt_d = cnt_q + 1'b1;
    end else if (rd_en && !wr_en) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ===== hdl/pom_front.sv =====
// Front end: accepts samples and computes panel power in a two-stage pipeline.
module pom_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  output logic             full_o,
  input  pom_pkg::in_item_t in_item_i,
  output logic             work_push_o,
  output pom_pkg::work_t   work_o,
  input  logic             work_full_i
);

  import pom_pkg::*;

  logic        s1_v_q, s1_v_d, s2_v_q, s2_v_d;
  logic [2:0]  s1_panel_q, s2_panel_q;
  logic        s1_shut_q, s2_shut_q, s1_start_q, s2_start_q;
  logic [21:0] s1_prod_q;
  logic [12:0] s2_power_q;
  logic [44:0] scaled;
  logic        s2_free, s1_free, accept, s2_load;

  assign s2_free = !s2_v_q || !work_full_i;
  assign s1_free = !s1_v_q || s2_free;
  assign full_o  = !s1_free;
  assign accept  = push_i && s1_free;
  assign s2_load = s1_v_q && s2_free;

  assign scaled = 45'(s1_prod_q) * 45'(Recip1000);

  always_comb begin
    s1_v_d = s1_v_q;
    s2_v_d = s2_v_q;
    if (s2_free) begin
      s2_v_d = s1_v_q;
      s1_v_d = 1'b0;
    end
    if (accept) begin
      s1_v_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      s1_v_q <= s1_v_d;
      s2_v_q <= s2_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_panel_q <= in_item_i.panel;
      s1_shut_q  <= in_item_i.shutdown;
      s1_start_q <= in_item_i.cycle_start;
      s1_prod_q  <= 22'(in_item_i.current_sample) * 22'(in_item_i.voltage_sample[11:2]);
    end
    if (s2_load) begin
      s2_panel_q <= s1_panel_q;
      s2_shut_q  <= s1_shut_q;
      s2_start_q <= s1_start_q;
      s2_power_q <= scaled[RecipShift+12:RecipShift];
    end
  end

  assign work_push_o        = s2_v_q && !work_full_i;
  assign work_o.panel       = s2_panel_q;
  assign work_o.shutdown    = s2_shut_q;
  assign work_o.cycle_start = s2_start_q;
  assign work_o.power       = s2_power_q;

endmodule

// ===== hdl/pom_back.sv =====
// Back end: per-panel tracking state, compare and perturb, and the settings.
module pom_back #(
  parameter int unsigned PanelCount = 6
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pom_pkg::cfg_wr_t  cfg_i,
  input  logic              work_empty_i,
  input  pom_pkg::work_t    work_i,
  output logic              work_pop_o,
  input  logic              res_full_i,
  output logic              res_push_o,
  output pom_pkg::out_item_t res_o
);

  import pom_pkg::*;

  localparam int unsigned IdxW = (PanelCount > 1) ? $clog2(PanelCount) : 1;

  logic [9:0]  step_q, ppc_q;
  logic [11:0] max_q, min_q, nom_q;

  logic [11:0] setting_q [PanelCount];
  logic        dir_q     [PanelCount];
  logic [12:0] prev_q    [PanelCount];
  logic [9:0]  count_q   [PanelCount];

  logic        go, in_range, upd, do_p;
  logic [IdxW-1:0] idx;
  logic [11:0] setting_d;
  logic        dir_d;
  logic [12:0] prev_d;
  logic [9:0]  count_d;
  logic signed [13:0] moved;

  assign go         = !work_empty_i && !res_full_i;
  assign work_pop_o = go;
  assign res_push_o = go;
  assign idx        = IdxW'(work_i.panel);
  assign in_range   = (32'(work_i.panel) < PanelCount);

  always_comb begin
    setting_d = setting_q[idx];
    dir_d     = dir_q[idx];
    prev_d    = prev_q[idx];
    count_d   = count_q[idx];
    upd       = 1'b0;
    do_p      = 1'b0;
    if (work_i.cycle_start) begin
      upd     = 1'b1;
      prev_d  = work_i.power;
      dir_d   = 1'b1;
      count_d = '0;
      do_p    = (ppc_q != '0) && !work_i.shutdown;
    end else if (count_q[idx] < ppc_q) begin
      upd     = 1'b1;
      if (!work_i.shutdown && (work_i.power <= prev_q[idx])) begin
        dir_d = !dir_q[idx];
      end
      prev_d  = work_i.power;
      count_d = count_q[idx] + 1'b1;
      do_p    = (count_d < ppc_q) && !work_i.shutdown;
    end
    moved = dir_d ? $signed({2'b00, setting_q[idx]}) + $signed({4'b0000, step_q})
                  : $signed({2'b00, setting_q[idx]}) - $signed({4'b0000, step_q});
    if (do_p) begin
      if (moved > $signed({2'b00, max_q}) || moved < $signed({2'b00, min_q})) begin
        setting_d = nom_q;
      end else begin
        setting_d = moved[11:0];
      end
    end
  end

  always_comb begin
    res_o.panel_out   = work_i.panel;
    res_o.power_value = work_i.power;
    if (in_range) begin
      res_o.current_setting = setting_d;
      res_o.direction_up    = dir_d;
      res_o.perturbed       = do_p;
      res_o.cycle_done      = (count_d >= ppc_q);
    end else begin
      res_o.current_setting = '0;
      res_o.direction_up    = 1'b0;
      res_o.perturbed       = 1'b0;
      res_o.cycle_done      = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= StepSizeReset;
      max_q  <= SettingMaxReset;
      min_q  <= SettingMinReset;
      nom_q  <= SettingNominalReset;
      ppc_q  <= PerturbsPerCycleReset;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CfgStepSize:         step_q <= cfg_i.data[9:0];
        CfgSettingMax:       max_q  <= cfg_i.data;
        CfgSettingMin:       min_q  <= cfg_i.data;
        CfgSettingNominal:   nom_q  <= cfg_i.data;
        CfgPerturbsPerCycle: ppc_q  <= cfg_i.data[9:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < PanelCount; i++) begin
        setting_q[i] <= SettingNominalReset;
        dir_q[i]     <= 1'b1;
        count_q[i]   <= '0;
      end
    end else if (go && in_range && upd) begin
      setting_q[idx] <= setting_d;
      dir_q[idx]     <= dir_d;
      count_q[idx]   <= count_d;
    end
  end

  // The baseline power has no reset; it is valid once a cycle start has been seen.
  always_ff @(posedge clk_i) begin
    if (go && in_range && upd) begin
      prev_q[idx] <= prev_d;
    end
  end

endmodule

// ===== tb/tb_perturb_observe_mppt.sv =====
// Self-checking testbench for the multi-panel perturb-and-observe power point tracker.
`timescale 1ns / 1ps

module tb_perturb_observe_mppt;
  import pom_pkg::*;

  localparam int unsigned PanelCount  = 6;
  localparam int          DrainCycles = 16;
  // An index past the last register; a write to it must leave every setting alone.
  localparam logic [2:0]  CfgIndexUnused = 3'd7;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       push = 1'b0;
  logic       full;
  in_item_t   in_item = '0;
  logic       empty;
  logic       pop = 1'b0;
  out_item_t  out_item;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [11:0] cfg_data = '0;

  perturb_observe_mppt #(
    .PANEL_COUNT(PanelCount)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_item_i  (in_item),
    .empty      (empty),
    .pop        (pop),
    .out_item_o (out_item),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Tracker settings as the block should hold them.
  logic [9:0]  cfg_step;
  logic [11:0] cfg_max;
  logic [11:0] cfg_min;
  logic [11:0] cfg_nominal;
  logic [9:0]  cfg_ppc;

  // Per-panel tracker state as the block should hold it.
  logic [11:0] trk_setting    [PanelCount];
  logic        trk_dir_up     [PanelCount];
  logic [12:0] trk_base_power [PanelCount];
  logic [9:0]  trk_count      [PanelCount];

  // Stimulus-side view of each panel, so that measurements only follow a cycle start.
  bit          gen_started [8];
  int          gen_count   [8];
  logic [11:0] last_cur    [8];
  logic [11:0] last_volt   [8];

  in_item_t  sample_q[$];
  out_item_t pending_results[$];
  int        err_cnt = 0;
  bit        tx_quiet = 1'b0;
  bit        rx_quiet = 1'b0;

  task automatic report_mismatch(input string msg);
    err_cnt++;
    $display("%0t: %s", $time, msg);
  endtask

  // Moves a panel's setting by one step, falling back to nominal outside min..max.
  function automatic void nudge_setting(int p);
    int n;
    n = trk_dir_up[p] ? int'(trk_setting[p]) + int'(cfg_step)
                      : int'(trk_setting[p]) - int'(cfg_step);
    if (n > int'(cfg_max) || n < int'(cfg_min)) begin
      trk_setting[p] = cfg_nominal;
    end else begin
      trk_setting[p] = 12'(n);
    end
  endfunction

  // Applies one accepted sample to the tracker state and returns the result item it yields.
  function automatic out_item_t track_sample(in_item_t s);
    out_item_t r;
    logic [12:0] pw;
    logic moved;
    int p;
    pw = 13'((int'(s.current_sample) * int'(s.voltage_sample[11:2])) / 1000);
    r = '0;
    r.panel_out = s.panel;
    r.power_value = pw;
    if (s.panel >= PanelCount) begin
      return r;
    end
    p = int'(s.panel);
    moved = 1'b0;
    if (s.cycle_start) begin
      trk_base_power[p] = pw;
      trk_dir_up[p] = 1'b1;
      trk_count[p] = '0;
      if (trk_count[p] < cfg_ppc && !s.shutdown) begin
        nudge_setting(p);
        moved = 1'b1;
      end
    end else if (trk_count[p] < cfg_ppc) begin
      // Power that did not rise means the last step went the wrong way.
      if (!s.shutdown && pw <= trk_base_power[p]) begin
        trk_dir_up[p] = !trk_dir_up[p];
      end
      trk_base_power[p] = pw;
      trk_count[p] = trk_count[p] + 10'd1;
      if (trk_count[p] < cfg_ppc && !s.shutdown) begin
        nudge_setting(p);
        moved = 1'b1;
      end
    end
    r.current_setting = trk_setting[p];
    r.direction_up = trk_dir_up[p];
    r.perturbed = moved;
    r.cycle_done = (trk_count[p] >= cfg_ppc);
    return r;
  endfunction

  // Sample driver: one item per accepted push, with random gaps unless told to stay quiet.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        pending_results.push_back(track_sample(in_item));
      end
      if (!push || !full) begin
        if (sample_q.size() > 0 && (tx_quiet || $urandom_range(0, 99) >= 10)) begin
          in_item <= sample_q.pop_front();
          push <= 1'b1;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // Result monitor: pops with random stalls unless quiet, checks each item against the oldest prediction.
  always @(posedge clk_i) begin : result_mon
    out_item_t want;
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("result item for panel %0d with nothing expected",
                                    out_item.panel_out));
        end else begin
          want = pending_results.pop_front();
          if (out_item.panel_out !== want.panel_out)
            report_mismatch($sformatf("panel_out got %0d expected %0d",
                                      out_item.panel_out, want.panel_out));
          if (out_item.current_setting !== want.current_setting)
            report_mismatch($sformatf("panel %0d current_setting got %0d expected %0d",
                            want.panel_out, out_item.current_setting, want.current_setting));
          if (out_item.direction_up !== want.direction_up)
            report_mismatch($sformatf("panel %0d direction_up got %0b expected %0b",
                            want.panel_out, out_item.direction_up, want.direction_up));
          if (out_item.power_value !== want.power_value)
            report_mismatch($sformatf("panel %0d power_value got %0d expected %0d",
                            want.panel_out, out_item.power_value, want.power_value));
          if (out_item.perturbed !== want.perturbed)
            report_mismatch($sformatf("panel %0d perturbed got %0b expected %0b",
                            want.panel_out, out_item.perturbed, want.perturbed));
          if (out_item.cycle_done !== want.cycle_done)
            report_mismatch($sformatf("panel %0d cycle_done got %0b expected %0b",
                            want.panel_out, out_item.cycle_done, want.cycle_done));
        end
      end
      pop <= rx_quiet || ($urandom_range(0, 99) >= 10);
    end
  end

  // Waits until every queued item is in and every result is out, then lets the pipeline drain.
  task automatic settle();
    do @(negedge clk_i);
    while (sample_q.size() != 0 || push || pending_results.size() != 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [11:0] val);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk_i);
    while (!cfg_ready);
    case (idx)
      CfgStepSize:         cfg_step    = val[9:0];
      CfgSettingMax:       cfg_max     = val;
      CfgSettingMin:       cfg_min     = val;
      CfgSettingNominal:   cfg_nominal = val;
      CfgPerturbsPerCycle: cfg_ppc     = val[9:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  // The two spare upper bits of the 10-bit registers get random values; they must be ignored.
  task automatic configure(input logic [11:0] stp, mx, mn, nm, pc);
    settle();
    write_reg(CfgStepSize, {2'($urandom), stp[9:0]});
    write_reg(CfgSettingMax, mx);
    write_reg(CfgSettingMin, mn);
    write_reg(CfgSettingNominal, nm);
    write_reg(CfgPerturbsPerCycle, {2'($urandom), pc[9:0]});
  endtask

  // Ordinary operating point: sane bounds, nominal inside them, short cycles.
  task automatic configure_typical();
    logic [11:0] mx, mn;
    mx = 12'($urandom_range(2500, 4095));
    mn = 12'($urandom_range(0, 1500));
    configure(12'($urandom_range(1, 200)), mx, mn, 12'($urandom_range(mn, mx)),
              12'($urandom_range(2, 30)));
  endtask

  function automatic void add_item(logic [2:0] pn, logic [11:0] cur, volt, logic sd, st);
    in_item_t s;
    s.panel = pn;
    s.current_sample = cur;
    s.voltage_sample = volt;
    s.shutdown = sd;
    s.cycle_start = st;
    sample_q.push_back(s);
    if (st) begin
      gen_started[pn] = 1'b1;
      gen_count[pn] = 0;
    end else if (gen_count[pn] < int'(cfg_ppc)) begin
      gen_count[pn]++;
    end
    last_cur[pn] = cur;
    last_volt[pn] = volt;
  endfunction

  // Often values near the panel's last sample, so power both rises and falls by small steps; else extremes or random.
  function automatic logic [11:0] pick_value(logic [11:0] last);
    int roll, v;
    roll = $urandom_range(0, 99);
    if (roll < 10) return 12'h000;
    if (roll < 20) return 12'hFFF;
    if (roll < 25) return last;
    if (roll < 60) begin
      v = int'(last) + int'($urandom_range(0, 64)) - 32;
      if (v < 0) v = 0;
      if (v > 4095) v = 4095;
      return 12'(v);
    end
    return 12'($urandom);
  endfunction

  // One random sample. Panels run well-formed cycles; a few items restart a cycle early,
  // land after the cycle is over, or name a panel that does not exist.
  function automatic void add_random(output bit counted);
    logic [2:0] pn;
    logic st, sd;
    if ($urandom_range(0, 99) < 5) begin
      pn = 3'($urandom_range(PanelCount, 7));
    end else begin
      pn = 3'($urandom_range(0, PanelCount - 1));
    end
    sd = ($urandom_range(0, 99) < 8);
    if (pn >= PanelCount) begin
      st = 1'($urandom_range(0, 1));
      counted = 1'b0;
    end else begin
      if (!gen_started[pn]) st = 1'b1;
      else if (gen_count[pn] >= int'(cfg_ppc)) st = ($urandom_range(0, 3) != 0);
      else st = ($urandom_range(0, 99) < 3);
      counted = st || (gen_count[pn] < int'(cfg_ppc));
    end
    add_item(pn, pick_value(last_cur[pn]), pick_value(last_volt[pn]), sd, st);
  endfunction

  task automatic random_phase(input int n, input bit quiet, input bit pause_mid);
    int useful;
    bit hit;
    tx_quiet = quiet;
    rx_quiet = quiet;
    useful = 0;
    while (useful < n) begin
      add_random(hit);
      if (hit) useful++;
      // Hold the sender back until the block has returned everything so far.
      if (pause_mid && hit && useful == n / 2) settle();
    end
  endtask

  initial begin : stimulus
    cfg_step    = StepSizeReset;
    cfg_max     = SettingMaxReset;
    cfg_min     = SettingMinReset;
    cfg_nominal = SettingNominalReset;
    cfg_ppc     = PerturbsPerCycleReset;
    for (int i = 0; i < PanelCount; i++) begin
      trk_setting[i]    = SettingNominalReset;
      trk_dir_up[i]     = 1'b1;
      trk_base_power[i] = '0;
      trk_count[i]      = '0;
    end
    for (int i = 0; i < 8; i++) begin
      gen_started[i] = 1'b0;
      gen_count[i]   = 0;
      last_cur[i]    = '0;
      last_volt[i]   = '0;
    end
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: rising, equal and falling power, shutdown, and missing panels.
    add_item(3'd0, 12'hFFF, 12'hFFF, 1'b0, 1'b1);  // highest possible power as baseline
    add_item(3'd0, 12'hFFF, 12'hFFF, 1'b0, 1'b0);  // equal power reverses
    add_item(3'd0, 12'h000, 12'h000, 1'b0, 1'b0);  // falling power reverses
    add_item(3'd0, 12'hFFF, 12'hFFF, 1'b0, 1'b0);  // rising power keeps direction
    add_item(3'd1, 12'd2000, 12'd3, 1'b0, 1'b1);   // quarter voltage rounds to zero
    add_item(3'd1, 12'h000, 12'hFFF, 1'b0, 1'b0);
    add_item(3'd5, 12'd1234, 12'd2345, 1'b1, 1'b1); // start while shut down
    add_item(3'd5, 12'd100, 12'd100, 1'b1, 1'b0);
    add_item(3'd5, 12'd4000, 12'd4000, 1'b0, 1'b0);
    add_item(3'd6, 12'hFFF, 12'hFFF, 1'b1, 1'b1);
    add_item(3'd7, 12'h000, 12'h000, 1'b0, 1'b0);
    add_item(3'd2, 12'hAAA, 12'h555, 1'b0, 1'b1);
    add_item(3'd2, 12'h555, 12'hAAA, 1'b0, 1'b0);
    add_item(3'd3, 12'd800, 12'd3000, 1'b0, 1'b1);
    add_item(3'd4, 12'd3000, 12'd800, 1'b0, 1'b1);

    // Largest step and one perturbation per cycle, so cycles end and later items are held.
    configure(12'd1023, 12'd4095, 12'd0, 12'd0, 12'd1);
    add_item(3'd0, 12'd500, 12'd500, 1'b0, 1'b1);
    add_item(3'd0, 12'd600, 12'd600, 1'b0, 1'b0);
    add_item(3'd0, 12'd700, 12'd700, 1'b0, 1'b0);
    add_item(3'd1, 12'd700, 12'd700, 1'b1, 1'b1);
    settle();
    write_reg(CfgIndexUnused, 12'hFFF);

    // Inverted bounds; with no perturbations per cycle a start finishes the cycle at once.
    configure(12'd1, 12'd0, 12'd4095, 12'd4095, 12'd0);
    add_item(3'd2, 12'd900, 12'd900, 1'b0, 1'b1);
    add_item(3'd2, 12'd950, 12'd950, 1'b0, 1'b0);
    configure(12'd1, 12'd0, 12'd4095, 12'd4095, 12'd3);
    add_item(3'd3, 12'd100, 12'd2000, 1'b0, 1'b1);
    add_item(3'd3, 12'd50, 12'd2000, 1'b0, 1'b0);

    // Random part over several settings, one of them without any gaps on either side.
    configure_typical();
    random_phase(125, 1'b0, 1'b0);
    configure_typical();
    random_phase(125, 1'b0, 1'b1);
    configure(12'd1023, 12'd4095, 12'd0, 12'd4095, 12'd1023);
    random_phase(125, 1'b1, 1'b0);
    configure(12'd16, 12'd4000, 12'd100, 12'd2048, 12'd100);
    random_phase(125, 1'b0, 1'b0);
    configure(12'd1, 12'd0, 12'd0, 12'd0, 12'd1);
    random_phase(125, 1'b0, 1'b0);
    configure(12'($urandom_range(1, 1023)), 12'($urandom_range(0, 1000)),
              12'($urandom_range(2000, 4095)), 12'($urandom), 12'($urandom_range(2, 20)));
    random_phase(125, 1'b0, 1'b0);

    settle();
    if (err_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // A correct run needs well under a tenth of this.
  initial begin : watchdog
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
